// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the controller checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define CHK_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/errc_pkg.sv
// ----------------------------------------------------------------------------
// errc_pkg
// Constants, register map, control words and microcode table of the
// EWMA / double EWMA run-to-run controller.
// ----------------------------------------------------------------------------
package errc_pkg;

    localparam int VALUE_WIDTH_DEF   = 24;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int GAIN_W            = 24;
    localparam int CFG_DATA_W        = 32;
    localparam int CFG_IDX_W         = 3;
    localparam int PC_W              = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TREND_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CONV_LIMIT = 3'd4;

    localparam logic       RST_MODE       = 1'b1;
    localparam int         RST_TARGET     = 56320;
    localparam int         RST_SMOOTHING  = 19661;
    localparam int         RST_TREND_GAIN = 28087;
    localparam int         RST_CONV_LIMIT = 1024;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_MUL  = 2'd1;
    localparam logic [1:0] OP_UPD  = 2'd2;
    localparam logic [1:0] OP_FIN  = 2'd3;

    localparam logic [PC_W-1:0] PC_LOAD = 3'd0;
    localparam logic [PC_W-1:0] PC_MUL1 = 3'd1;
    localparam logic [PC_W-1:0] PC_UPD1 = 3'd2;
    localparam logic [PC_W-1:0] PC_MUL2 = 3'd3;
    localparam logic [PC_W-1:0] PC_UPD2 = 3'd4;
    localparam logic [PC_W-1:0] PC_MUL3 = 3'd5;
    localparam logic [PC_W-1:0] PC_FIN  = 3'd6;

    typedef struct packed {
        logic [1:0]      op;
        logic            a_gain;
        logic            upd_z2;
        logic            jmp_ewma;
        logic [PC_W-1:0] jmp_addr;
    } cw_t;

    typedef struct packed {
        logic       take;
        logic       step;
        logic [1:0] op;
        logic       a_gain;
        logic       upd_z2;
    } ctrl_t;

    function automatic cw_t rom_word(input logic [PC_W-1:0] pc);
        cw_t w;
        w = '{op: OP_FIN, a_gain: 1'b0, upd_z2: 1'b0, jmp_ewma: 1'b0, jmp_addr: PC_FIN};
        unique case (pc)
            PC_LOAD: w.op = OP_LOAD;
            PC_MUL1: w.op = OP_MUL;
            PC_UPD1:
            begin
                w.op       = OP_UPD;
                w.jmp_ewma = 1'b1;
            end
            PC_MUL2: w.op = OP_MUL;
            PC_UPD2:
            begin
                w.op     = OP_UPD;
                w.upd_z2 = 1'b1;
            end
            PC_MUL3:
            begin
                w.op     = OP_MUL;
                w.a_gain = 1'b1;
            end
            PC_FIN:  w.op = OP_FIN;
            default: w.op = OP_FIN;
        endcase
        return w;
    endfunction

endpackage

// File: rtl/errc_seq.sv
// ----------------------------------------------------------------------------
// errc_seq
// Microcode sequencer: step counter, table fetch and conditional jump.
// ----------------------------------------------------------------------------
module errc_seq
    import errc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  meas_valid,
    output logic  meas_ready,
    input  logic  mode,
    input  logic  stall,
    output ctrl_t ctrl
);

    logic            busy_reg;
    logic            busy_next;
    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    cw_t             cw;
    logic            take;
    logic            hold;

    assign cw         = rom_word(pc_reg);
    assign meas_ready = !busy_reg;
    assign take       = meas_valid && !busy_reg;
    assign hold       = (cw.op == OP_FIN) && stall;

    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (take)
        begin
            busy_next = 1'b1;
            pc_next   = PC_LOAD;
        end
        else if (busy_reg && !hold)
        begin
            if (cw.op == OP_FIN)
                busy_next = 1'b0;
            else if (cw.jmp_ewma && !mode)
                pc_next = cw.jmp_addr;
            else
                pc_next = pc_reg + PC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= PC_LOAD;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    assign ctrl.take   = take;
    assign ctrl.step   = busy_reg && !hold;
    assign ctrl.op     = cw.op;
    assign ctrl.a_gain = cw.a_gain;
    assign ctrl.upd_z2 = cw.upd_z2;

endmodule

// File: rtl/errc_dp.sv
// ----------------------------------------------------------------------------
// errc_dp
// Datapath: shared multiplier, smoother registers, lot statistics and the
// result register.
// ----------------------------------------------------------------------------
module errc_dp
    import errc_pkg::*;
#(
    parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  ctrl_t                         ctrl,
    input  logic                          mode,
    input  logic signed [VALUE_WIDTH-1:0] target,
    input  logic [FRACTION_BITS:0]        smoothing,
    input  logic [GAIN_W-1:0]             trend_gain,
    input  logic [VALUE_WIDTH-2:0]        converge_limit,
    input  logic signed [VALUE_WIDTH-1:0] measured,
    input  logic                          last_run,
    input  logic                          res_ready,
    output logic                          res_valid,
    output logic signed [VALUE_WIDTH-1:0] correction,
    output logic signed [VALUE_WIDTH-1:0] run_error,
    output logic signed [VALUE_WIDTH-1:0] level_estimate,
    output logic signed [VALUE_WIDTH-1:0] trend_estimate,
    output logic [VALUE_WIDTH-2:0]        max_abs_error,
    output logic                          converged,
    output logic                          lot_done
);

    localparam int V  = VALUE_WIDTH;
    localparam int F  = FRACTION_BITS;
    localparam int AW = (F + 1 > GAIN_W) ? F + 1 : GAIN_W;
    localparam int OW = V + 1;
    localparam int PW = AW + V + 2;
    localparam int SW = AW + V + 3;

    localparam logic signed [SW-1:0] SAT_HI   = {{(SW-V+1){1'b0}}, {(V-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO   = {{(SW-V+1){1'b1}}, {(V-1){1'b0}}};
    localparam logic signed [SW-1:0] RND_HALF = {{(SW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
    localparam logic [F:0]           LAM_ONE  = {1'b1, {F{1'b0}}};

    function automatic logic signed [V-1:0] sat_v(input logic signed [SW-1:0] x);
        if (x > SAT_HI)
            return SAT_HI[V-1:0];
        else if (x < SAT_LO)
            return SAT_LO[V-1:0];
        else
            return x[V-1:0];
    endfunction

    function automatic logic signed [SW-1:0] rnd_f(input logic signed [PW-1:0] p);
        logic signed [SW-1:0] e;
        e = SW'(p) + RND_HALF;
        return e >>> F;
    endfunction

    logic signed [V-1:0]  meas_reg;
    logic                 last_reg;
    logic signed [V-1:0]  z1_reg, z1_next;
    logic signed [V-1:0]  z2_reg, z2_next;
    logic signed [V-1:0]  corr_reg, corr_next;
    logic [V-2:0]         peak_reg, peak_next;
    logic signed [OW-1:0] opnd_reg, opnd_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic                 res_valid_reg, res_valid_next;

    logic [F:0]           lam;
    logic [AW-1:0]        mul_a;
    logic signed [V-1:0]  raw;
    logic signed [V-1:0]  upd_base;
    logic signed [V-1:0]  upd_val;
    logic signed [SW-1:0] level_w;
    logic signed [SW-1:0] trend_w;
    logic signed [V-1:0]  err;
    logic [V-1:0]         aerr_w;
    logic [V-2:0]         aerr;
    logic [V-2:0]         peak_new;
    logic signed [V-1:0]  corr_val;
    logic                 fin;

    assign lam       = (smoothing > LAM_ONE) ? LAM_ONE : smoothing;
    assign mul_a     = ctrl.a_gain ? AW'(trend_gain) : AW'(lam);
    assign prod_next = $signed({1'b0, mul_a}) * opnd_reg;

    assign raw      = sat_v(SW'(meas_reg) - SW'(corr_reg) - SW'(target));
    assign upd_base = ctrl.upd_z2 ? z2_reg : z1_reg;
    assign upd_val  = sat_v(SW'(upd_base) + rnd_f(prod_reg));

    assign level_w  = mode ? (SW'(z1_reg) + SW'(z1_reg) - SW'(z2_reg)) : SW'(z1_reg);
    assign trend_w  = mode ? rnd_f(prod_reg) : '0;
    assign corr_val = sat_v(-(level_w + trend_w));

    assign err      = sat_v(SW'(meas_reg) - SW'(target));
    assign aerr_w   = err[V-1] ? (~err + V'(1)) : err;
    assign aerr     = aerr_w[V-1] ? {(V-1){1'b1}} : aerr_w[V-2:0];
    assign peak_new = (aerr > peak_reg) ? aerr : peak_reg;

    assign fin = ctrl.step && (ctrl.op == OP_FIN);

    always_comb
    begin
        z1_next        = z1_reg;
        z2_next        = z2_reg;
        corr_next      = corr_reg;
        peak_next      = peak_reg;
        opnd_next      = opnd_reg;
        res_valid_next = res_valid_reg && !res_ready;
        if (ctrl.step)
        begin
            unique case (ctrl.op)
                OP_LOAD: opnd_next = OW'(raw) - OW'(z1_reg);
                OP_MUL:  opnd_next = opnd_reg;
                OP_UPD:
                begin
                    if (ctrl.upd_z2)
                    begin
                        z2_next   = upd_val;
                        opnd_next = OW'(z1_reg) - OW'(upd_val);
                    end
                    else
                    begin
                        z1_next   = upd_val;
                        opnd_next = OW'(upd_val) - OW'(z2_reg);
                    end
                end
                OP_FIN:
                begin
                    res_valid_next = 1'b1;
                    if (last_reg)
                    begin
                        z1_next   = '0;
                        z2_next   = '0;
                        corr_next = '0;
                        peak_next = '0;
                    end
                    else
                    begin
                        corr_next = corr_val;
                        peak_next = peak_new;
                    end
                end
                default: opnd_next = opnd_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            z1_reg        <= '0;
            z2_reg        <= '0;
            corr_reg      <= '0;
            peak_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            z1_reg        <= z1_next;
            z2_reg        <= z2_next;
            corr_reg      <= corr_next;
            peak_reg      <= peak_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.take)
        begin
            meas_reg <= measured;
            last_reg <= last_run;
        end
        opnd_reg <= opnd_next;
        if (ctrl.step && (ctrl.op == OP_MUL))
            prod_reg <= prod_next;
        if (fin)
        begin
            correction     <= corr_val;
            run_error      <= err;
            level_estimate <= sat_v(level_w);
            trend_estimate <= sat_v(trend_w);
            max_abs_error  <= peak_new;
            converged      <= aerr < converge_limit;
            lot_done       <= last_reg;
        end
    end

    assign res_valid = res_valid_reg;

endmodule

// File: rtl/ewma_run_to_run_controller.sv
// ----------------------------------------------------------------------------
// ewma_run_to_run_controller
// The microcode program steps one shared multiplier through load, multiply,
// update and finish in EWMA mode; double EWMA mode adds a second multiply and
// update and a trend-gain multiply. Requests are taken only while idle.
// Reset: registers return to their defaults, smoothers and lot state clear.
// ----------------------------------------------------------------------------
module ewma_run_to_run_controller
    import errc_pkg::*;
#(
    parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          meas_valid,
    output logic                          meas_ready,
    input  logic signed [VALUE_WIDTH-1:0] measured,
    input  logic                          last_run,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic signed [VALUE_WIDTH-1:0] correction,
    output logic signed [VALUE_WIDTH-1:0] run_error,
    output logic signed [VALUE_WIDTH-1:0] level_estimate,
    output logic signed [VALUE_WIDTH-1:0] trend_estimate,
    output logic [VALUE_WIDTH-2:0]        max_abs_error,
    output logic                          converged,
    output logic                          lot_done
);

    logic                          mode_reg;
    logic signed [VALUE_WIDTH-1:0] target_reg;
    logic [FRACTION_BITS:0]        smoothing_reg;
    logic [GAIN_W-1:0]             trend_gain_reg;
    logic [VALUE_WIDTH-2:0]        conv_limit_reg;
    ctrl_t                         ctrl;
    logic                          stall;

    assign cfg_ready = 1'b1;
    assign stall     = res_valid && !res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= RST_MODE;
            target_reg     <= VALUE_WIDTH'(RST_TARGET);
            smoothing_reg  <= (FRACTION_BITS + 1)'(RST_SMOOTHING);
            trend_gain_reg <= GAIN_W'(RST_TREND_GAIN);
            conv_limit_reg <= (VALUE_WIDTH - 1)'(RST_CONV_LIMIT);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MODE:       mode_reg       <= cfg_data[0];
                REG_TARGET:     target_reg     <= cfg_data[VALUE_WIDTH-1:0];
                REG_SMOOTHING:  smoothing_reg  <= cfg_data[FRACTION_BITS:0];
                REG_TREND_GAIN: trend_gain_reg <= cfg_data[GAIN_W-1:0];
                REG_CONV_LIMIT: conv_limit_reg <= cfg_data[VALUE_WIDTH-2:0];
                default:        mode_reg       <= mode_reg;
            endcase
        end
    end

    errc_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .meas_valid (meas_valid),
        .meas_ready (meas_ready),
        .mode       (mode_reg),
        .stall      (stall),
        .ctrl       (ctrl)
    );

    errc_dp #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .mode           (mode_reg),
        .target         (target_reg),
        .smoothing      (smoothing_reg),
        .trend_gain     (trend_gain_reg),
        .converge_limit (conv_limit_reg),
        .measured       (measured),
        .last_run       (last_run),
        .res_ready      (res_ready),
        .res_valid      (res_valid),
        .correction     (correction),
        .run_error      (run_error),
        .level_estimate (level_estimate),
        .trend_estimate (trend_estimate),
        .max_abs_error  (max_abs_error),
        .converged      (converged),
        .lot_done       (lot_done)
    );

endmodule

// File: rtl/errc_checker.sv
// ----------------------------------------------------------------------------
// errc_checker
// Port-level checks of the run-to-run controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module errc_checker
    import errc_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          meas_valid,
    input logic                          meas_ready,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic signed [VALUE_WIDTH-1:0] correction,
    input logic signed [VALUE_WIDTH-1:0] run_error,
    input logic [VALUE_WIDTH-2:0]        max_abs_error
);

    // one request in flight at a time
    `CHK_NEXT(a_busy_after_req, clk, rst_n, meas_valid && meas_ready, !meas_ready)
    `CHK_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(correction))
    // a new result only comes out of a running sequence
    `CHK_NOW(a_res_from_req, clk, rst_n, $rose(res_valid), $past(!meas_ready))
    // lot peak never below this run's error
    `CHK_NOW(a_peak_covers_err, clk, rst_n, res_valid && !run_error[VALUE_WIDTH-1], max_abs_error >= run_error[VALUE_WIDTH-2:0])

endmodule

bind ewma_run_to_run_controller errc_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_errc_checker (.*);
